@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the conditioner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/tcfsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Flame sensor conditioner package
// Widths, constants, codes and shared types of the conditioner.
// ----------------------------------------------------------------------------
package tcfsc_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEVEL_W = 10;
  localparam int SUM_W = LEVEL_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_SH = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int RECIP = ((1 << RECIP_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int FRAC_W = 16;
  localparam int EMA_W = LEVEL_W + FRAC_W;
  localparam int WGT_W = 16;
  localparam logic [WGT_W-1:0] EMA_KEEP = 16'd62259;
  localparam logic [WGT_W-1:0] EMA_TAKE = 16'd3277;

  localparam int CNT_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CALIB  = 2'd1,
    OP_CHECK  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_DETECT_THR  = 2'd0,
    CFG_DRIFT_THR   = 2'd1,
    CFG_MIN_SAMPLES = 2'd2,
    CFG_COOLDOWN    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             sample;
    logic             calib;
    logic             ema_upd;
    logic [PTR_W-1:0] pos;
  } chan_ctrl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mean_next;
    logic               flame_next;
    logic               drift;
  } chan_stat_t;

endpackage

@@ sv/tcfsc_if.sv @@
// ----------------------------------------------------------------------------
// Conditioner channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tcfsc_in_if;
  import tcfsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [LEVEL_W-1:0] sample_a;
  logic [LEVEL_W-1:0] sample_b;
  logic [LEVEL_W-1:0] sample_c;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, opcode, sample_a, sample_b, sample_c, now_ms,
                  input ready);
  modport sink (input valid, opcode, sample_a, sample_b, sample_c, now_ms,
                output ready);
endinterface

interface tcfsc_out_if;
  import tcfsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] smoothed_a;
  logic [LEVEL_W-1:0] smoothed_b;
  logic [LEVEL_W-1:0] smoothed_c;
  logic               flame_seen;
  logic               drift_warning;
  logic [CNT_W-1:0]   good_sample_count;

  modport source (output valid, smoothed_a, smoothed_b, smoothed_c, flame_seen,
                  drift_warning, good_sample_count, input ready);
  modport sink (input valid, smoothed_a, smoothed_b, smoothed_c, flame_seen,
                drift_warning, good_sample_count, output ready);
endinterface

@@ sv/tcfsc_channel.sv @@
// ----------------------------------------------------------------------------
// Conditioner light channel
// Sample ring with running window sum, window mean, ambient level and EMA
// baseline of one light channel, with its flame and drift tests.
// ----------------------------------------------------------------------------
module tcfsc_channel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcfsc_pkg::chan_ctrl_t       ctrl_i,
  input  logic [tcfsc_pkg::LEVEL_W-1:0] sample_i,
  input  logic [tcfsc_pkg::LEVEL_W-1:0] detect_thr_i,
  input  logic [tcfsc_pkg::LEVEL_W-1:0] drift_thr_i,
  output tcfsc_pkg::chan_stat_t       stat_o
);
  import tcfsc_pkg::*;

  logic [LEVEL_W-1:0] ring_q [WINDOW_DEPTH];
  logic [SUM_W-1:0]   sum_q, sum_d, calib_sum;
  logic [LEVEL_W-1:0] mean_q, mean_new, amb_q, amb_next;
  logic [EMA_W-1:0]   ema_q, ema_new;
  logic [PROD_W-1:0]  mean_prod;
  logic [EMA_W+WGT_W-1:0] keep_prod;
  logic [LEVEL_W+WGT_W-1:0] take_prod;
  logic [EMA_W:0]     ref_lvl, ema_ext, dev, limit;

  assign calib_sum = SUM_W'(SUM_W'(sample_i) * SUM_W'(WINDOW_DEPTH));
  assign sum_d = sum_q - SUM_W'(ring_q[ctrl_i.pos]) + SUM_W'(sample_i);
  assign mean_prod = PROD_W'(sum_d) * PROD_W'(RECIP);
  assign mean_new = mean_prod[RECIP_SH +: LEVEL_W];

  assign keep_prod = (EMA_W+WGT_W)'(ema_q) * (EMA_W+WGT_W)'(EMA_KEEP);
  assign take_prod = (LEVEL_W+WGT_W)'(mean_new) * (LEVEL_W+WGT_W)'(EMA_TAKE);
  assign ema_new = keep_prod[FRAC_W +: EMA_W] + EMA_W'(take_prod);

  assign stat_o.mean_next = ctrl_i.sample ? mean_new : mean_q;
  assign amb_next = ctrl_i.calib ? sample_i : amb_q;
  assign stat_o.flame_next = {1'b0, amb_next} >
                             ({1'b0, stat_o.mean_next} + {1'b0, detect_thr_i});

  assign ref_lvl = {1'b0, amb_q, {FRAC_W{1'b0}}};
  assign ema_ext = {1'b0, ema_q};
  assign dev = (ema_ext >= ref_lvl) ? (ema_ext - ref_lvl) : (ref_lvl - ema_ext);
  assign limit = {1'b0, drift_thr_i, {FRAC_W{1'b0}}};
  assign stat_o.drift = dev > limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      sum_q  <= '0;
      mean_q <= '0;
      amb_q  <= LEVEL_MAX;
      ema_q  <= {LEVEL_MAX, {FRAC_W{1'b0}}};
    end else begin
      if (ctrl_i.sample) begin
        ring_q[ctrl_i.pos] <= sample_i;
        sum_q  <= sum_d;
        mean_q <= mean_new;
      end else if (ctrl_i.calib) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          ring_q[i] <= sample_i;
        end
        sum_q <= calib_sum;
        amb_q <= sample_i;
        ema_q <= {sample_i, {FRAC_W{1'b0}}};
      end
      if (ctrl_i.ema_upd) begin
        ema_q <= ema_new;
      end
    end
  end

endmodule

@@ sv/three_channel_flame_sensor_conditioner_core.sv @@
// ----------------------------------------------------------------------------
// Three-channel flame sensor conditioner
// An input transfer lands in the input register and its result is loaded into
// the result register once that is free or being read; one item per cycle,
// stalled only by a waiting result. Ring sums, means and EMA baselines are
// updated at the edge that loads the result.
// Reset is asynchronous and returns the sensor state, the configuration
// registers and both valid flags to their default values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_channel_flame_sensor_conditioner_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [tcfsc_pkg::CFG_W-1:0]  cfg_wdata_i,
  tcfsc_in_if.sink                     in_ch_i,
  tcfsc_out_if.source                  out_ch_o
);
  import tcfsc_pkg::*;

  logic [LEVEL_W-1:0] detect_thr_q, drift_thr_q;
  logic [CNT_W-1:0]   min_samples_q;
  logic [CNT_W-1:0]   cooldown_q;

  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [LEVEL_W-1:0] s1_smp_q [3];
  logic [TIME_W-1:0]  s1_now_q;

  logic [PTR_W-1:0]   pos_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TIME_W-1:0]  cool_end_q;
  logic               drift_q, drift_d;

  logic               out_valid_q;
  logic [LEVEL_W-1:0] out_mean_q [3];
  logic               out_flame_q, out_drift_q;
  logic [CNT_W-1:0]   out_count_q;

  logic               fire, in_ready, do_sample, flame_any, drift_any, ema_upd;
  chan_ctrl_t         ctrl;
  chan_stat_t         stat [3];

  assign fire     = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ready = !s1_valid_q || fire;
  assign in_ch_i.ready = in_ready;

  assign do_sample = fire && (s1_op_q == OP_SAMPLE);
  assign flame_any = stat[0].flame_next || stat[1].flame_next || stat[2].flame_next;
  assign drift_any = stat[0].drift || stat[1].drift || stat[2].drift;
  assign ema_upd   = do_sample && !flame_any && (s1_now_q >= cool_end_q);

  assign ctrl.sample  = do_sample;
  assign ctrl.calib   = fire && (s1_op_q == OP_CALIB);
  assign ctrl.ema_upd = ema_upd;
  assign ctrl.pos     = pos_q;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    tcfsc_channel u_chan (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sample_i     (s1_smp_q[ch]),
      .detect_thr_i (detect_thr_q),
      .drift_thr_i  (drift_thr_q),
      .stat_o       (stat[ch])
    );
  end

  always_comb begin
    count_d = count_q;
    drift_d = drift_q;
    case (s1_op_q)
      OP_SAMPLE: begin
        if (ema_upd && (count_q != COUNT_MAX)) begin
          count_d = count_q + 1'b1;
        end
      end
      OP_CALIB: begin
        count_d = '0;
        drift_d = 1'b0;
      end
      OP_CHECK: begin
        if (count_q >= min_samples_q) begin
          drift_d = drift_any;
        end
      end
      default: begin
        drift_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_thr_q  <= 10'd100;
      drift_thr_q   <= 10'd50;
      min_samples_q <= 16'd100;
      cooldown_q    <= 16'd3000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DETECT_THR:  detect_thr_q  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_DRIFT_THR:   drift_thr_q   <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_MIN_SAMPLES: min_samples_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_COOLDOWN:    cooldown_q    <= cfg_wdata_i[CNT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch_i.valid) begin
      s1_op_q     <= op_e'(in_ch_i.opcode);
      s1_smp_q[0] <= in_ch_i.sample_a;
      s1_smp_q[1] <= in_ch_i.sample_b;
      s1_smp_q[2] <= in_ch_i.sample_c;
      s1_now_q    <= in_ch_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      count_q    <= '0;
      cool_end_q <= '0;
      drift_q    <= 1'b0;
    end else if (fire) begin
      count_q <= count_d;
      drift_q <= drift_d;
      if (do_sample) begin
        pos_q <= (pos_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        if (flame_any) begin
          cool_end_q <= s1_now_q + TIME_W'(cooldown_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_mean_q[ch] <= stat[ch].mean_next;
      end
      out_flame_q <= flame_any;
      out_drift_q <= drift_d;
      out_count_q <= count_d;
    end
  end

  assign out_ch_o.valid             = out_valid_q;
  assign out_ch_o.smoothed_a        = out_mean_q[0];
  assign out_ch_o.smoothed_b        = out_mean_q[1];
  assign out_ch_o.smoothed_c        = out_mean_q[2];
  assign out_ch_o.flame_seen        = out_flame_q;
  assign out_ch_o.drift_warning     = out_drift_q;
  assign out_ch_o.good_sample_count = out_count_q;

  `ASSERT_NEXT(a_count_holds, clk_i, rst_ni, !fire, $stable(count_q))
  `ASSERT_NEXT(a_drift_source, clk_i, rst_ni, !(fire && (s1_op_q == OP_CHECK)), !$rose(drift_q))
  `ASSERT_IMPLIES(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, in_ready)

endmodule
